>>> hw/rtl/ethip_pkg.sv
// ----------------------------------------------------------------------------
// ethip_pkg: shared types and constants for the Ethernet/IPv4/TCP header parser
// Holds the record kinds, the frame layout offsets and the structs that pass
// between the input stage, the parser and the result stage.
// ----------------------------------------------------------------------------
package ethip_pkg;

   // Record kinds on the result channel
   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_CHAR   = 2'd1,
      KIND_END    = 2'd2
   } record_kind_type;

   // Protocol codes
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  IPPROTO_TCP    = 8'd6;

   // Frame layout (byte offsets from the start of the frame)
   localparam int MAC_LEN         = 6;
   localparam int ETH_HDR_LEN     = 14;
   localparam int POS_TYPE_LAST   = 13;
   localparam int POS_IHL         = 14;
   localparam int POS_PROTO       = 23;
   localparam int POS_SRC_IP      = 26;
   localparam int POS_DST_IP      = 30;
   localparam int POS_IP_END      = 34;
   localparam int TCP_OFFSET_BYTE = 12;

   // Smallest legal IHL and TCP data offset, in 32-bit words
   localparam logic [3:0] MIN_HDR_WORDS = 4'd5;

   // Printable range and the substitute character
   localparam logic [7:0] PRINT_LOW  = 8'h20;
   localparam logic [7:0] PRINT_HIGH = 8'h7E;
   localparam logic [7:0] DOT_CHAR   = 8'h2E;

   // Width and reset value of the preview limit register
   localparam int          PREVIEW_W     = 6;
   localparam logic [5:0]  PREVIEW_RESET = 6'd32;

   // One input byte transaction
   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_end;
   } item_type;

   // One result record
   typedef struct packed {
      record_kind_type record_kind;
      logic [47:0]     dst_mac;
      logic [47:0]     src_mac;
      logic [31:0]     src_addr;
      logic [31:0]     dst_addr;
      logic [15:0]     src_port;
      logic [15:0]     dst_port;
      logic [7:0]      shown_char;
      logic [4:0]      char_index;
      logic            packet_end;
   } result_type;

endpackage

>>> hw/rtl/ethip_in_stage.sv
// ----------------------------------------------------------------------------
// ethip_in_stage: input register of the header parser
// Captures one byte transaction and holds it until the parser consumes it.
// ----------------------------------------------------------------------------
module ethip_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ethip_pkg::item_type req_item,
   input  logic               advance,
   output logic               item_valid,
   output ethip_pkg::item_type item
);
   import ethip_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     load;

   // Accept when empty or when the held transaction moves on this cycle
   assign req_ready = !valid_ff || advance;
   assign load      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = req_item;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> hw/rtl/ethip_parse.sv
// ----------------------------------------------------------------------------
// ethip_parse: frame parser state and record decision
// Tracks the byte position, captures header fields, checks EtherType, protocol,
// IHL and data offset, and decides the record each byte causes.
// ----------------------------------------------------------------------------
module ethip_parse #(
   parameter int MAX_FRAME_BYTES = 1518,
   parameter int MAX_PREVIEW     = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  ethip_pkg::item_type        item,
   input  logic [ethip_pkg::PREVIEW_W-1:0] preview_limit,
   output logic                       emit,
   output ethip_pkg::result_type      result
);
   import ethip_pkg::*;

   localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int CMP_W = (POS_W > 8) ? POS_W : 8;
   localparam logic [PREVIEW_W-1:0] PREVIEW_CAP = PREVIEW_W'(MAX_PREVIEW);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [47:0]      dst_mac_ff, dst_mac_in;
   logic [47:0]      src_mac_ff, src_mac_in;
   logic [15:0]      type_ff, type_in;
   logic [3:0]       ip_words_ff, ip_words_in;
   logic [6:0]       tcp_start_ff, tcp_start_in;
   logic [7:0]       hdr_end_ff, hdr_end_in;
   logic [31:0]      src_addr_ff, src_addr_in;
   logic [31:0]      dst_addr_ff, dst_addr_in;
   logic [15:0]      src_port_ff, src_port_in;
   logic [15:0]      dst_port_ff, dst_port_in;
   logic [3:0]       tcp_words_ff, tcp_words_in;
   logic             drop_ff, drop_in;
   logic             hdr_done_ff, hdr_done_in;
   logic [PREVIEW_W-1:0] count_ff, count_in;

   logic [CMP_W-1:0]     pos_x, ts_x, end_x;
   logic                 in_range;
   logic [PREVIEW_W-1:0] lim;
   logic [7:0]           b;
   record_kind_type      kind;

   assign pos_x    = CMP_W'(pos_ff);
   assign ts_x     = CMP_W'(tcp_start_ff);
   assign end_x    = CMP_W'(hdr_end_ff);
   assign in_range = pos_ff < POS_W'(MAX_FRAME_BYTES);
   assign lim      = (preview_limit > PREVIEW_CAP) ? PREVIEW_CAP : preview_limit;
   assign b        = item.data_byte;

   // Update parser state and pick the record for this byte
   always_comb begin
      pos_in       = pos_ff;
      dst_mac_in   = dst_mac_ff;
      src_mac_in   = src_mac_ff;
      type_in      = type_ff;
      ip_words_in  = ip_words_ff;
      tcp_start_in = tcp_start_ff;
      hdr_end_in   = hdr_end_ff;
      src_addr_in  = src_addr_ff;
      dst_addr_in  = dst_addr_ff;
      src_port_in  = src_port_ff;
      dst_port_in  = dst_port_ff;
      tcp_words_in = tcp_words_ff;
      drop_in      = drop_ff;
      hdr_done_in  = hdr_done_ff;
      count_in     = count_ff;
      emit         = 1'b0;
      kind         = KIND_HEADER;

      if (advance && in_range) begin
         pos_in = pos_ff + POS_W'(1);
         if (!drop_ff) begin
            priority if (pos_x < CMP_W'(MAC_LEN)) begin
               dst_mac_in = {dst_mac_ff[39:0], b};
            end else if (pos_x < CMP_W'(2 * MAC_LEN)) begin
               src_mac_in = {src_mac_ff[39:0], b};
            end else if (pos_x < CMP_W'(ETH_HDR_LEN)) begin
               type_in = {type_ff[7:0], b};
               if (pos_x == CMP_W'(POS_TYPE_LAST) && type_in != ETHERTYPE_IPV4) begin
                  drop_in = 1'b1;
               end
            end else if (pos_x == CMP_W'(POS_IHL)) begin
               ip_words_in  = b[3:0];
               tcp_start_in = 7'(ETH_HDR_LEN) + {1'b0, b[3:0], 2'b00};
               if (b[3:0] < MIN_HDR_WORDS) begin
                  drop_in = 1'b1;
               end
            end else begin
               // Check protocol, capture addresses, ports and data offset
               if (pos_x == CMP_W'(POS_PROTO) && b != IPPROTO_TCP) begin
                  drop_in = 1'b1;
               end
               if (pos_x >= CMP_W'(POS_SRC_IP) && pos_x < CMP_W'(POS_DST_IP)) begin
                  src_addr_in = {src_addr_ff[23:0], b};
               end else if (pos_x >= CMP_W'(POS_DST_IP) && pos_x < CMP_W'(POS_IP_END)) begin
                  dst_addr_in = {dst_addr_ff[23:0], b};
               end
               if (pos_x == ts_x || pos_x == ts_x + CMP_W'(1)) begin
                  src_port_in = {src_port_ff[7:0], b};
               end else if (pos_x == ts_x + CMP_W'(2) || pos_x == ts_x + CMP_W'(3)) begin
                  dst_port_in = {dst_port_ff[7:0], b};
               end else if (pos_x == ts_x + CMP_W'(TCP_OFFSET_BYTE)) begin
                  tcp_words_in = b[7:4];
                  hdr_end_in   = {1'b0, tcp_start_ff} + {2'b00, b[7:4], 2'b00} - 8'd1;
                  if (b[7:4] < MIN_HDR_WORDS) begin
                     drop_in = 1'b1;
                  end
               end
               // Emit the header record, then payload characters
               if (!drop_in) begin
                  if (hdr_done_ff) begin
                     if (count_ff < lim) begin
                        emit     = 1'b1;
                        kind     = KIND_CHAR;
                        count_in = count_ff + PREVIEW_W'(1);
                     end
                  end else if (tcp_words_ff >= MIN_HDR_WORDS && pos_x == end_x) begin
                     hdr_done_in = 1'b1;
                     emit        = 1'b1;
                     kind        = KIND_HEADER;
                  end
               end
            end
         end
      end

      // Close the packet on its last byte and clear the frame state
      if (advance && item.frame_end) begin
         if (!drop_in && hdr_done_in && !emit) begin
            emit = 1'b1;
            kind = KIND_END;
         end
         if (drop_in || !hdr_done_in) begin
            emit = 1'b0;
         end
         pos_in       = '0;
         dst_mac_in   = '0;
         src_mac_in   = '0;
         type_in      = '0;
         ip_words_in  = '0;
         tcp_start_in = '0;
         hdr_end_in   = '0;
         src_addr_in  = '0;
         dst_addr_in  = '0;
         src_port_in  = '0;
         dst_port_in  = '0;
         tcp_words_in = '0;
         drop_in      = 1'b0;
         hdr_done_in  = 1'b0;
         count_in     = '0;
      end
   end

   // Build the record from the captured fields
   always_comb begin
      result             = '0;
      result.record_kind = kind;
      result.packet_end  = item.frame_end;
      if (kind == KIND_HEADER) begin
         result.dst_mac  = dst_mac_ff;
         result.src_mac  = src_mac_ff;
         result.src_addr = src_addr_ff;
         result.dst_addr = dst_addr_ff;
         result.src_port = src_port_ff;
         result.dst_port = dst_port_ff;
      end
      if (kind == KIND_CHAR) begin
         result.shown_char = (b >= PRINT_LOW && b <= PRINT_HIGH) ? b : DOT_CHAR;
         result.char_index = count_ff[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         dst_mac_ff   <= '0;
         src_mac_ff   <= '0;
         type_ff      <= '0;
         ip_words_ff  <= '0;
         tcp_start_ff <= '0;
         hdr_end_ff   <= '0;
         src_addr_ff  <= '0;
         dst_addr_ff  <= '0;
         src_port_ff  <= '0;
         dst_port_ff  <= '0;
         tcp_words_ff <= '0;
         drop_ff      <= 1'b0;
         hdr_done_ff  <= 1'b0;
         count_ff     <= '0;
      end else begin
         pos_ff       <= pos_in;
         dst_mac_ff   <= dst_mac_in;
         src_mac_ff   <= src_mac_in;
         type_ff      <= type_in;
         ip_words_ff  <= ip_words_in;
         tcp_start_ff <= tcp_start_in;
         hdr_end_ff   <= hdr_end_in;
         src_addr_ff  <= src_addr_in;
         dst_addr_ff  <= dst_addr_in;
         src_port_ff  <= src_port_in;
         dst_port_ff  <= dst_port_in;
         tcp_words_ff <= tcp_words_in;
         drop_ff      <= drop_in;
         hdr_done_ff  <= hdr_done_in;
         count_ff     <= count_in;
      end
   end

   // Position advances by one on every byte below MAX_FRAME_BYTES that does not end the frame
   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      advance && in_range && !item.frame_end |=> pos_ff == $past(pos_ff) + POS_W'(1))
      else $error("byte position did not advance");

   // Frame state is clear after a frame end
   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      advance && item.frame_end |=> pos_ff == '0 && !drop_ff && !hdr_done_ff && count_ff == '0)
      else $error("frame state not cleared after frame end");

   // Payload characters only follow a completed header
   a_char_after_hdr: assert property (@(posedge clock) disable iff (reset)
      emit && kind == KIND_CHAR |-> hdr_done_ff && !drop_ff)
      else $error("payload character before header record");

   // Preview count never passes its cap
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= PREVIEW_CAP)
      else $error("payload count exceeds preview cap");

endmodule

>>> hw/rtl/ethip_out_stage.sv
// ----------------------------------------------------------------------------
// ethip_out_stage: result register of the header parser
// Holds one record until the consumer takes it, and reports room for the next.
// ----------------------------------------------------------------------------
module ethip_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  emit,
   input  ethip_pkg::result_type result,
   output logic                  can_take,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ethip_pkg::result_type rsp_result
);
   import ethip_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff, result_in;

   // Room when empty or when the held record leaves this cycle
   assign can_take = !valid_ff || rsp_ready;

   always_comb begin
      valid_in  = valid_ff && !rsp_ready;
      result_in = result_ff;
      if (advance) begin
         valid_in = emit;
         if (emit) begin
            result_in = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

>>> hw/rtl/ethernet_ipv4_tcp_header_parser.sv
// ----------------------------------------------------------------------------
// ethernet_ipv4_tcp_header_parser: Ethernet/IPv4/TCP header parser top level
// Parses a captured frame byte by byte and emits a header record followed by
// a preview of the TCP payload.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle while the result register has room, and gives
// at most one record per byte. A byte passes an input register and then the
// parser into a result register, where its record is held; the parser state
// is updated once per byte as it leaves the input register, which sets the
// one-byte-per-cycle rate. Frames that are not IPv4 carrying TCP, have
// an IHL or data offset below 5, or end before the headers are complete give
// no records. A TCP frame gives a header record on its last header byte, then
// up to preview_limit payload characters (capped at MAX_PREVIEW), and its last
// record carries packet_end; an end marker record is sent when the last byte
// has nothing else to show. Bytes at or beyond MAX_FRAME_BYTES are ignored
// except for their frame end. Write csr_wr_data only while the block is idle.
// ----------------------------------------------------------------------------
module ethernet_ipv4_tcp_header_parser #(
   parameter int MAX_FRAME_BYTES = 1518,
   parameter int MAX_PREVIEW     = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_frame_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_record_kind,
   output logic [47:0] rsp_dst_mac,
   output logic [47:0] rsp_src_mac,
   output logic [31:0] rsp_src_addr,
   output logic [31:0] rsp_dst_addr,
   output logic [15:0] rsp_src_port,
   output logic [15:0] rsp_dst_port,
   output logic [7:0]  rsp_shown_char,
   output logic [4:0]  rsp_char_index,
   output logic        rsp_packet_end,
   input  logic        csr_wr_en,
   input  logic [ethip_pkg::PREVIEW_W-1:0] csr_wr_data
);
   import ethip_pkg::*;

   logic [PREVIEW_W-1:0] preview_limit_ff, preview_limit_in;
   item_type             req_item, item;
   logic                 item_valid;
   logic                 can_take;
   logic                 advance;
   logic                 emit;
   result_type           result, rsp_result;

   // Hold the preview limit register
   assign preview_limit_in = csr_wr_en ? csr_wr_data : preview_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         preview_limit_ff <= PREVIEW_RESET;
      end else begin
         preview_limit_ff <= preview_limit_in;
      end
   end

   assign req_item.data_byte = req_data_byte;
   assign req_item.frame_end = req_frame_end;

   // Move a byte into the parser when the result side has room
   assign advance = item_valid && can_take;

   ethip_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   ethip_parse #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
      .MAX_PREVIEW     (MAX_PREVIEW)
   ) u_parse (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .item          (item),
      .preview_limit (preview_limit_ff),
      .emit          (emit),
      .result        (result)
   );

   ethip_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .emit       (emit),
      .result     (result),
      .can_take   (can_take),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result)
   );

   assign rsp_record_kind = rsp_result.record_kind;
   assign rsp_dst_mac     = rsp_result.dst_mac;
   assign rsp_src_mac     = rsp_result.src_mac;
   assign rsp_src_addr    = rsp_result.src_addr;
   assign rsp_dst_addr    = rsp_result.dst_addr;
   assign rsp_src_port    = rsp_result.src_port;
   assign rsp_dst_port    = rsp_result.dst_port;
   assign rsp_shown_char  = rsp_result.shown_char;
   assign rsp_char_index  = rsp_result.char_index;
   assign rsp_packet_end  = rsp_result.packet_end;

endmodule
